// ===== src/bmirq_pkg.sv =====
// Shared types, codes and constants for the bank mapper with IRQ counter.
package bmirq_pkg;

	// Item codes carried on the opcode field.
	typedef enum logic [2:0] {
		OP_CPU_READ  = 3'd0,
		OP_CPU_WRITE = 3'd1,
		OP_PPU_READ  = 3'd2,
		OP_PPU_WRITE = 3'd3,
		OP_TICK      = 3'd4,
		OP_IRQ_ACK   = 3'd5,
		OP_REINIT    = 3'd6
	} op_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT = 2'd1;

	// Register decode codes: address bits 15:12 followed by address bit 4.
	localparam logic [4:0] REG_PRG0       = 5'b1000_0;
	localparam logic [4:0] REG_PRG1       = 5'b1000_1;
	localparam logic [4:0] REG_PRG2       = 5'b1001_0;
	localparam logic [4:0] REG_AUDIO_SEL  = 5'b1001_1;
	localparam logic [4:0] REG_CHR0       = 5'b1010_0;
	localparam logic [4:0] REG_CHR1       = 5'b1010_1;
	localparam logic [4:0] REG_CHR2       = 5'b1011_0;
	localparam logic [4:0] REG_CHR3       = 5'b1011_1;
	localparam logic [4:0] REG_CHR4       = 5'b1100_0;
	localparam logic [4:0] REG_CHR5       = 5'b1100_1;
	localparam logic [4:0] REG_CHR6       = 5'b1101_0;
	localparam logic [4:0] REG_CHR7       = 5'b1101_1;
	localparam logic [4:0] REG_MIRROR     = 5'b1110_0;
	localparam logic [4:0] REG_IRQ_RELOAD = 5'b1110_1;
	localparam logic [4:0] REG_IRQ_CTRL   = 5'b1111_0;
	localparam logic [4:0] REG_IRQ_ACK    = 5'b1111_1;

	// Sound data port: address bits 15:12 and 5:4.
	localparam logic [3:0] AUDIO_PORT_HI  = 4'h9;
	localparam logic [1:0] AUDIO_PORT_LO  = 2'b11;

	// Scanline prescaler constants.
	localparam logic [9:0] PRESCALE_RELOAD = 10'd341;
	localparam logic [9:0] PRESCALE_STEP   = 10'd3;
	localparam logic [9:0] PRESCALE_WRAP   = 10'd338;

	// Reset value of the bank count registers.
	localparam logic [7:0] PRG_COUNT_RESET = 8'd8;
	localparam logic [7:0] CHR_COUNT_RESET = 8'd0;

	// Request to the modulo unit.
	typedef struct packed {
		logic        start;
		logic [7:0]  dividend;
		logic [10:0] divisor;
	} mod_req_t;

	// Status and result of the modulo unit.
	typedef struct packed {
		logic       busy;
		logic       last;
		logic [7:0] rem;
	} mod_rsp_t;

	// Initial bank of the third program window: the 8 KB total minus two.
	function automatic logic [7:0] window2_init(input logic [7:0] prg_count);
		logic [8:0] total;
		logic [8:0] diff;
		total = {prg_count, 1'b0};
		diff  = total - 9'd2;
		return (prg_count != 8'd0) ? diff[7:0] : 8'd0;
	endfunction

endpackage

// ===== src/bmirq_mod.sv =====
// Restoring modulo unit: reduces an 8-bit bank number by a bank count, one bit a cycle.
module bmirq_mod (
	input  logic                clk,
	input  logic                arst_n,
	input  bmirq_pkg::mod_req_t req,
	output bmirq_pkg::mod_rsp_t rsp
);

	logic        busy_q;
	logic [2:0]  cnt_q;
	logic [7:0]  dvd_q;
	logic [10:0] div_q;
	logic [7:0]  rem_q;

	logic [8:0]  trial;
	logic [10:0] trial_ext;
	logic [10:0] diff;
	logic [7:0]  rem_next;

	// One restoring step: shift in the next dividend bit and subtract if it fits.
	always_comb begin
		trial     = {rem_q, dvd_q[7]};
		trial_ext = {2'b00, trial};
		diff      = trial_ext - div_q;
		rem_next  = (trial_ext >= div_q) ? diff[7:0] : trial[7:0];
	end

	// Control: eight steps after each start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd7;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 3'd1;
			if (cnt_q == 3'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: operands are latched at start, the remainder builds up bit by bit.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= 8'd0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[6:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.last = busy_q && (cnt_q == 3'd0);
	assign rsp.rem  = rem_q;

endmodule

// ===== src/bank_mapper_with_irq_counter.sv =====
// Top level of the cartridge bank mapper with IRQ counter and sound-port forwarder.
//
// Usage: bus accesses and events enter on the input channel (in_valid/in_ready with
// opcode, bus_address and write_data). Each item gives exactly one result on the
// output channel (out_valid/out_ready) carrying the translated offset, the claim
// flag, the mirroring mode, the IRQ line and any forwarded sound-register write.
// Bank counts are set through the configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high and writes belong in idle time.
// Every item is reduced through one shared restoring modulo unit that handles one
// bit per cycle. An accepted item takes eight modulo steps in the divide state,
// then its result is committed from the done state, and in_ready stays low until
// the sequencer is back in idle. The result sits in an output register, so the
// next item is taken while it waits; if the receiver stalls, the following item
// finishes its modulo steps and then holds until the output register frees.
// Reset clears all mapper state to its power-up values and the bank counts to 8
// and 0; a reinitialise item does the same but keeps the bank counts.
module bank_mapper_with_irq_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        handled,
	output logic [21:0] mapped_offset,
	output logic [1:0]  mirroring,
	output logic        irq_line,
	output logic        audio_write,
	output logic [5:0]  audio_register,
	output logic [7:0]  audio_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	bmirq_pkg::state_t state_q, state_next;

	// Configuration registers.
	logic [7:0] prg_count_q;
	logic [7:0] chr_count_q;

	// Mapper state.
	logic [7:0] prg_win_q [3];
	logic [7:0] chr_slot_q [8];
	logic [1:0] mirror_q;
	logic       irq_en_q;
	logic       irq_reen_q;
	logic       irq_cycle_q;
	logic       irq_pend_q;
	logic [7:0] irq_reload_q;
	logic [7:0] irq_count_q;
	logic [9:0] presc_q;
	logic [5:0] audio_sel_q;

	// Captured item.
	bmirq_pkg::op_t op_q;
	logic [15:0]    addr_q;
	logic [7:0]     data_q;

	// Output register.
	logic        out_valid_q;
	logic        handled_q;
	logic [21:0] offset_q;
	logic [1:0]  mirroring_q;
	logic        irq_line_q;
	logic        audio_write_q;
	logic [5:0]  audio_reg_q;
	logic [7:0]  audio_val_q;

	// Handshake and sequencer controls.
	logic in_xfer;
	logic commit;

	bmirq_pkg::mod_req_t mod_req;
	bmirq_pkg::mod_rsp_t mod_rsp;

	// Bank totals.
	logic [8:0]  prg_total;
	logic [10:0] chr_total;

	// Next state and result computed from the captured item.
	logic [7:0] n_prg_win [3];
	logic [7:0] n_chr_slot [8];
	logic [1:0] n_mirror;
	logic       n_irq_en;
	logic       n_irq_reen;
	logic       n_irq_cycle;
	logic       n_irq_pend;
	logic [7:0] n_irq_reload;
	logic [7:0] n_irq_count;
	logic [9:0] n_presc;
	logic [5:0] n_audio_sel;
	logic       clock_cnt;
	logic       r_handled;
	logic [21:0] r_offset;
	logic       r_aw;
	logic [5:0] r_areg;
	logic [7:0] r_aval;
	logic [8:0] prg_bank;
	logic [4:0] reg_code;

	// Bank totals in 8 KB program units and 1 KB pattern units.
	assign prg_total = (prg_count_q == 8'd0) ? 9'd1 : {prg_count_q, 1'b0};
	assign chr_total = (chr_count_q == 8'd0) ? 11'd8 : {chr_count_q, 3'b000};

	// Sequencer next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			bmirq_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_next = bmirq_pkg::ST_DIV;
				end
			end
			bmirq_pkg::ST_DIV: begin
				if (mod_rsp.last) begin
					state_next = bmirq_pkg::ST_DONE;
				end
			end
			bmirq_pkg::ST_DONE: begin
				if (commit) begin
					state_next = bmirq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bmirq_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			bmirq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			bmirq_pkg::ST_DONE: begin
				commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign in_xfer = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmirq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Operand selection for the modulo unit at the input transfer.
	always_comb begin
		mod_req.start = in_xfer;
		if (opcode == bmirq_pkg::OP_CPU_READ) begin
			case (bus_address[14:13])
				2'b00:   mod_req.dividend = prg_win_q[0];
				2'b01:   mod_req.dividend = prg_win_q[1];
				default: mod_req.dividend = prg_win_q[2];
			endcase
			mod_req.divisor = {2'b00, prg_total};
		end else begin
			mod_req.dividend = chr_slot_q[bus_address[12:10]];
			mod_req.divisor  = chr_total;
		end
	end

	bmirq_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Capture the item.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= bmirq_pkg::op_t'(opcode);
			addr_q <= bus_address;
			data_q <= write_data;
		end
	end

	// Item effect on the mapper state and the result fields.
	always_comb begin
		n_prg_win    = prg_win_q;
		n_chr_slot   = chr_slot_q;
		n_mirror     = mirror_q;
		n_irq_en     = irq_en_q;
		n_irq_reen   = irq_reen_q;
		n_irq_cycle  = irq_cycle_q;
		n_irq_pend   = irq_pend_q;
		n_irq_reload = irq_reload_q;
		n_irq_count  = irq_count_q;
		n_presc      = presc_q;
		n_audio_sel  = audio_sel_q;
		clock_cnt    = 1'b0;
		r_handled    = 1'b0;
		r_offset     = 22'd0;
		r_aw         = 1'b0;
		r_areg       = 6'd0;
		r_aval       = 8'd0;
		reg_code     = {addr_q[15:12], addr_q[4]};
		prg_bank     = (addr_q[14:13] == 2'b11) ? (prg_total - 9'd1) : {1'b0, mod_rsp.rem};
		case (op_q)
			bmirq_pkg::OP_CPU_READ: begin
				if (addr_q[15]) begin
					r_handled = 1'b1;
					r_offset  = {prg_bank, addr_q[12:0]};
				end
			end
			bmirq_pkg::OP_CPU_WRITE: begin
				if (addr_q[15:12] == bmirq_pkg::AUDIO_PORT_HI &&
				    addr_q[5:4] == bmirq_pkg::AUDIO_PORT_LO) begin
					r_handled = 1'b1;
					r_aw      = 1'b1;
					r_areg    = audio_sel_q;
					r_aval    = data_q;
				end else begin
					r_handled = 1'b1;
					case (reg_code)
						bmirq_pkg::REG_PRG0:       n_prg_win[0] = {2'b00, data_q[5:0]};
						bmirq_pkg::REG_PRG1:       n_prg_win[1] = {2'b00, data_q[5:0]};
						bmirq_pkg::REG_PRG2:       n_prg_win[2] = {2'b00, data_q[5:0]};
						bmirq_pkg::REG_AUDIO_SEL:  n_audio_sel  = data_q[5:0];
						bmirq_pkg::REG_CHR0:       n_chr_slot[0] = data_q;
						bmirq_pkg::REG_CHR1:       n_chr_slot[1] = data_q;
						bmirq_pkg::REG_CHR2:       n_chr_slot[2] = data_q;
						bmirq_pkg::REG_CHR3:       n_chr_slot[3] = data_q;
						bmirq_pkg::REG_CHR4:       n_chr_slot[4] = data_q;
						bmirq_pkg::REG_CHR5:       n_chr_slot[5] = data_q;
						bmirq_pkg::REG_CHR6:       n_chr_slot[6] = data_q;
						bmirq_pkg::REG_CHR7:       n_chr_slot[7] = data_q;
						bmirq_pkg::REG_MIRROR:     n_mirror     = data_q[1:0];
						bmirq_pkg::REG_IRQ_RELOAD: n_irq_reload = data_q;
						bmirq_pkg::REG_IRQ_CTRL: begin
							n_irq_en    = data_q[1];
							n_irq_reen  = data_q[0];
							n_irq_cycle = data_q[2];
							n_irq_pend  = 1'b0;
							if (data_q[1]) begin
								n_irq_count = irq_reload_q;
								n_presc     = bmirq_pkg::PRESCALE_RELOAD;
							end
						end
						bmirq_pkg::REG_IRQ_ACK: begin
							n_irq_pend = 1'b0;
							n_irq_en   = irq_reen_q;
						end
						default: r_handled = 1'b0;
					endcase
				end
			end
			bmirq_pkg::OP_PPU_READ, bmirq_pkg::OP_PPU_WRITE: begin
				if (addr_q[15:13] == 3'b000 &&
				    (op_q == bmirq_pkg::OP_PPU_READ || chr_count_q == 8'd0)) begin
					r_handled = 1'b1;
					r_offset  = {4'd0, mod_rsp.rem, addr_q[9:0]};
				end
			end
			bmirq_pkg::OP_TICK: begin
				if (irq_en_q) begin
					if (irq_cycle_q) begin
						clock_cnt = 1'b1;
					end else if (presc_q <= bmirq_pkg::PRESCALE_STEP) begin
						n_presc   = presc_q + bmirq_pkg::PRESCALE_WRAP;
						clock_cnt = 1'b1;
					end else begin
						n_presc = presc_q - bmirq_pkg::PRESCALE_STEP;
					end
				end
			end
			bmirq_pkg::OP_IRQ_ACK: begin
				n_irq_pend = 1'b0;
			end
			bmirq_pkg::OP_REINIT: begin
				n_prg_win[0] = 8'd0;
				n_prg_win[1] = 8'd1;
				n_prg_win[2] = bmirq_pkg::window2_init(prg_count_q);
				for (int i = 0; i < 8; i++) begin
					n_chr_slot[i] = 8'(i);
				end
				n_mirror     = 2'd0;
				n_irq_en     = 1'b0;
				n_irq_reen   = 1'b0;
				n_irq_cycle  = 1'b0;
				n_irq_pend   = 1'b0;
				n_irq_reload = 8'd0;
				n_irq_count  = 8'd0;
				n_presc      = bmirq_pkg::PRESCALE_RELOAD;
				n_audio_sel  = 6'd0;
			end
			default: begin
				r_handled = 1'b0;
			end
		endcase
		// The counter reloads and flags an interrupt when it passes its top value.
		if (clock_cnt) begin
			if (irq_count_q == 8'hFF) begin
				n_irq_count = irq_reload_q;
				n_irq_pend  = 1'b1;
			end else begin
				n_irq_count = irq_count_q + 8'd1;
			end
		end
	end

	// Configuration registers and mapper state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q  <= bmirq_pkg::PRG_COUNT_RESET;
			chr_count_q  <= bmirq_pkg::CHR_COUNT_RESET;
			prg_win_q[0] <= 8'd0;
			prg_win_q[1] <= 8'd1;
			prg_win_q[2] <= bmirq_pkg::window2_init(bmirq_pkg::PRG_COUNT_RESET);
			for (int i = 0; i < 8; i++) begin
				chr_slot_q[i] <= 8'(i);
			end
			mirror_q     <= 2'd0;
			irq_en_q     <= 1'b0;
			irq_reen_q   <= 1'b0;
			irq_cycle_q  <= 1'b0;
			irq_pend_q   <= 1'b0;
			irq_reload_q <= 8'd0;
			irq_count_q  <= 8'd0;
			presc_q      <= bmirq_pkg::PRESCALE_RELOAD;
			audio_sel_q  <= 6'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bmirq_pkg::CFG_PRG_COUNT: prg_count_q <= cfg_data;
					bmirq_pkg::CFG_CHR_COUNT: chr_count_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (commit) begin
				prg_win_q    <= n_prg_win;
				chr_slot_q   <= n_chr_slot;
				mirror_q     <= n_mirror;
				irq_en_q     <= n_irq_en;
				irq_reen_q   <= n_irq_reen;
				irq_cycle_q  <= n_irq_cycle;
				irq_pend_q   <= n_irq_pend;
				irq_reload_q <= n_irq_reload;
				irq_count_q  <= n_irq_count;
				presc_q      <= n_presc;
				audio_sel_q  <= n_audio_sel;
			end
		end
	end

	assign cfg_ready = 1'b1;

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (commit) begin
			handled_q     <= r_handled;
			offset_q      <= r_offset;
			mirroring_q   <= n_mirror;
			irq_line_q    <= n_irq_pend;
			audio_write_q <= r_aw;
			audio_reg_q   <= r_areg;
			audio_val_q   <= r_aval;
		end
	end

	assign out_valid      = out_valid_q;
	assign handled        = handled_q;
	assign mapped_offset  = offset_q;
	assign mirroring      = mirroring_q;
	assign irq_line       = irq_line_q;
	assign audio_write    = audio_write_q;
	assign audio_register = audio_reg_q;
	assign audio_value    = audio_val_q;

	// An accepted item always starts the modulo unit.
	a_xfer_starts_mod: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> mod_rsp.busy && state_q == bmirq_pkg::ST_DIV)
		else $error("modulo unit not started after input transfer");

	// A result is committed only once the modulo unit has finished.
	a_commit_after_mod: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !mod_rsp.busy)
		else $error("result committed while modulo unit busy");

	// A new result appears only through a commit.
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(commit))
		else $error("output valid rose without a commit");

	// A pending interrupt implies the counter is enabled.
	a_pend_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		irq_pend_q |-> irq_en_q)
		else $error("interrupt pending while counter disabled");

endmodule
